// ===== rtl/vng_pkg.sv =====
// ---------------------------------------------------------------------------
// VNG demosaic package
// Types, table constants and defaults shared by the demosaic modules.
// ---------------------------------------------------------------------------
`default_nettype none

package vng_pkg;

   localparam int MAX_WIDTH_DEF = 4096;
   localparam int MAX_HEIGHT    = 4096;
   localparam int DIM_W         = 13;
   localparam int PIX_W         = 8;
   localparam int WIN_N         = 5;
   localparam int WIN_CELLS     = 25;
   localparam int DIRS          = 8;
   localparam int GRAD_W        = 11;
   localparam int SUM_W         = 13;
   localparam int NUM_W         = 15;
   localparam int QUO_W         = 11;
   localparam int CNT_W         = 4;
   localparam int STEP_W        = 4;
   localparam logic [STEP_W-1:0] DIV_FIN_STEP = STEP_W'(QUO_W + 1);
   localparam logic [DIM_W-1:0]  WIDTH_RESET  = 13'd640;
   localparam logic [DIM_W-1:0]  HEIGHT_RESET = 13'd480;

   localparam logic [1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_FRAME_HEIGHT = 2'd1;

   localparam logic [1:0] CHAN_BLUE  = 2'd0;
   localparam logic [1:0] CHAN_GREEN = 2'd1;
   localparam logic [1:0] CHAN_RED   = 2'd2;

   typedef struct packed {
      logic             mode;
      logic [PIX_W-1:0] pixel;
   } req_word_type;

   typedef struct packed {
      logic [PIX_W-1:0] blue;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] red;
      logic             frame_last;
   } rsp_word_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SHIFT,
      ST_GRAD,
      ST_SUM,
      ST_DIV,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic       load;
      logic       cfg;
      logic       shift;
      logic       grad;
      logic       sum;
      logic       div_load;
      logic       div_step;
      logic       div_fin;
      logic       out_load;
      logic [2:0] idx;
      logic [1:0] chan;
   } cmd_type;

   typedef struct packed {
      logic have;
      logic out_busy;
   } status_type;

   localparam logic [4:0] GRAD_TAB [DIRS][6][2] = '{
      '{'{7,17},'{2,12},'{6,16},'{8,18},'{1,11},'{3,13}},
      '{'{13,11},'{14,12},'{8,6},'{18,16},'{9,7},'{19,17}},
      '{'{17,7},'{22,12},'{18,8},'{16,6},'{23,13},'{21,11}},
      '{'{11,13},'{10,12},'{16,18},'{6,8},'{15,17},'{5,7}},
      '{'{8,16},'{4,12},'{7,11},'{13,17},'{3,7},'{9,13}},
      '{'{18,6},'{24,12},'{11,17},'{7,13},'{19,13},'{23,17}},
      '{'{6,18},'{0,12},'{11,17},'{7,13},'{5,11},'{1,7}},
      '{'{16,8},'{20,12},'{17,13},'{11,7},'{21,17},'{15,11}}
   };

   localparam logic [4:0] SUM_TAB [2][DIRS][3][4] = '{
      '{
         '{'{2,2,12,12},'{11,13,1,3},'{7,7,7,7}},
         '{'{14,14,12,12},'{13,13,13,13},'{9,7,19,17}},
         '{'{22,22,12,12},'{11,13,21,23},'{17,17,17,17}},
         '{'{10,10,12,12},'{11,11,11,11},'{5,7,15,17}},
         '{'{8,8,8,8},'{3,3,13,13},'{7,7,9,9}},
         '{'{18,18,18,18},'{13,13,23,23},'{17,17,19,19}},
         '{'{6,6,6,6},'{11,11,1,1},'{5,5,7,7}},
         '{'{16,16,16,16},'{11,11,21,21},'{15,15,17,17}}
      },
      '{
         '{'{7,7,7,7},'{6,6,8,8},'{12,12,2,2}},
         '{'{13,13,13,13},'{8,8,18,18},'{14,14,12,12}},
         '{'{17,17,17,17},'{18,18,16,16},'{22,22,12,12}},
         '{'{11,11,11,11},'{6,6,16,16},'{12,12,10,10}},
         '{'{7,13,3,9},'{8,8,8,8},'{12,12,4,4}},
         '{'{13,17,19,23},'{18,18,18,18},'{12,12,24,24}},
         '{'{1,5,7,11},'{6,6,6,6},'{0,0,12,12}},
         '{'{11,15,17,21},'{16,16,16,16},'{12,12,20,20}}
      }
   };

endpackage

`default_nettype wire

// ===== rtl/vng_ctrl.sv =====
// ---------------------------------------------------------------------------
// VNG demosaic controller
// Sequences one word through load, window shift, gradient and sum sweeps,
// division and result hand-over.
// ---------------------------------------------------------------------------
`default_nettype none

module vng_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  vng_pkg::status_type  status,
   output vng_pkg::cmd_type     cmd
);

   vng_pkg::state_type state_ff, state_in;
   logic [vng_pkg::STEP_W-1:0] step_ff, step_in;
   logic [1:0] chan_ff, chan_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= vng_pkg::ST_IDLE;
         step_ff  <= '0;
         chan_ff  <= vng_pkg::CHAN_BLUE;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         chan_ff  <= chan_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      chan_in  = chan_ff;
      case (state_ff)
         vng_pkg::ST_IDLE: begin
            if (!csr_valid && req_valid) begin
               state_in = vng_pkg::ST_SHIFT;
            end
         end
         vng_pkg::ST_SHIFT: begin
            step_in  = '0;
            state_in = status.have ? vng_pkg::ST_GRAD : vng_pkg::ST_IDLE;
         end
         vng_pkg::ST_GRAD: begin
            if (step_ff == vng_pkg::STEP_W'(vng_pkg::DIRS - 1)) begin
               step_in  = '0;
               state_in = vng_pkg::ST_SUM;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         vng_pkg::ST_SUM: begin
            if (step_ff == vng_pkg::STEP_W'(vng_pkg::DIRS - 1)) begin
               step_in  = '0;
               chan_in  = vng_pkg::CHAN_BLUE;
               state_in = vng_pkg::ST_DIV;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         vng_pkg::ST_DIV: begin
            if (step_ff == vng_pkg::DIV_FIN_STEP) begin
               step_in = '0;
               if (chan_ff == vng_pkg::CHAN_RED) begin
                  state_in = vng_pkg::ST_OUT;
               end else begin
                  chan_in = chan_ff + 1'b1;
               end
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         vng_pkg::ST_OUT: begin
            if (!status.out_busy) begin
               state_in = vng_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = vng_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      cmd.idx   = step_ff[2:0];
      cmd.chan  = chan_ff;
      csr_ready = 1'b0;
      req_ready = 1'b0;
      case (state_ff)
         vng_pkg::ST_IDLE: begin
            csr_ready = 1'b1;
            req_ready = !csr_valid;
            cmd.cfg   = csr_valid;
            cmd.load  = !csr_valid && req_valid;
         end
         vng_pkg::ST_SHIFT: cmd.shift = 1'b1;
         vng_pkg::ST_GRAD:  cmd.grad  = 1'b1;
         vng_pkg::ST_SUM:   cmd.sum   = 1'b1;
         vng_pkg::ST_DIV: begin
            cmd.div_load = (step_ff == '0);
            cmd.div_fin  = (step_ff == vng_pkg::DIV_FIN_STEP);
            cmd.div_step = (step_ff != '0) && (step_ff != vng_pkg::DIV_FIN_STEP);
         end
         vng_pkg::ST_OUT:   cmd.out_load = !status.out_busy;
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/vng_datapath.sv =====
// ---------------------------------------------------------------------------
// VNG demosaic datapath
// Line stores, 5x5 window, gradient and sum units, shared divider and the
// result register.
// ---------------------------------------------------------------------------
`default_nettype none

module vng_datapath #(
   parameter int MAX_WIDTH = vng_pkg::MAX_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  vng_pkg::cmd_type       cmd,
   output vng_pkg::status_type    status,
   input  vng_pkg::req_word_type  req_data,
   input  logic [1:0]             csr_index,
   input  logic [12:0]            csr_data,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output vng_pkg::rsp_word_type  rsp_data
);

   localparam int AW = $clog2(MAX_WIDTH);

   logic [12:0] width_ff, height_ff, col_ff, row_ff;
   logic [12:0] w_eff, h_eff, col_now, cr_now, cc_now;
   logic        have_now, last_now;
   logic [7:0]  pix_store, pix_now;
   logic [4:0]  col_ok_now, col_ok_ff;
   logic [3:0]  row_ok_now, row_ok_ff;
   logic [13:0] col_sum, row_sum;
   logic [1:0]  bank_ff;
   logic [7:0]  pix_ff;
   logic        have_ff, kind_ff, crodd_ff, last_ff;
   logic [7:0]  bank_q [4];
   logic [7:0]  win_ff [vng_pkg::WIN_CELLS];
   logic [7:0]  newcol [vng_pkg::WIN_N];
   logic [7:0]  a [vng_pkg::WIN_CELLS];
   logic [7:0]  gx, gy, ge;
   logic [vng_pkg::GRAD_W-1:0] g_sum;
   logic [vng_pkg::GRAD_W-1:0] g2_ff [vng_pkg::DIRS];
   logic [vng_pkg::GRAD_W-1:0] mn_ff, mx_ff;
   logic        pass;
   logic [9:0]  dir_sum [3];
   logic [vng_pkg::CNT_W-1:0] cnt_ff;
   logic [vng_pkg::SUM_W-1:0] s_ff [3];
   logic signed [vng_pkg::NUM_W-1:0] sv0, sv1, sv2, other, num;
   logic [vng_pkg::NUM_W-1:0] num_abs;
   logic [3:0]  rem_ff, rem_in;
   logic [vng_pkg::QUO_W-1:0] quo_ff, quo_in;
   logic        neg_ff;
   logic [4:0]  trial;
   logic        ge_cnt;
   logic signed [12:0] qs, val;
   logic [7:0]  sat;
   logic [7:0]  blue_ff, green_ff, red_ff;
   logic        rsp_valid_ff;
   vng_pkg::rsp_word_type rsp_data_ff;

   always_comb begin
      if (width_ff < 13'd3) begin
         w_eff = 13'd3;
      end else if ({2'b00, width_ff} > 15'(MAX_WIDTH)) begin
         w_eff = 13'(MAX_WIDTH);
      end else begin
         w_eff = width_ff;
      end
      if (height_ff < 13'd3) begin
         h_eff = 13'd3;
      end else if (height_ff > 13'(vng_pkg::MAX_HEIGHT)) begin
         h_eff = 13'(vng_pkg::MAX_HEIGHT);
      end else begin
         h_eff = height_ff;
      end
      col_now  = (col_ff >= w_eff) ? 13'd0 : col_ff;
      have_now = 1'b0;
      cr_now   = '0;
      cc_now   = '0;
      if (col_now >= 13'd2 && row_ff >= 13'd2) begin
         have_now = 1'b1;
         cr_now   = row_ff - 13'd2;
         cc_now   = col_now - 13'd2;
      end else if (col_now < 13'd2 && row_ff >= 13'd3) begin
         have_now = 1'b1;
         cr_now   = row_ff - 13'd3;
         cc_now   = w_eff - 13'd2 + col_now;
      end
      last_now  = (row_ff == h_eff + 13'd2) && (col_now == 13'd1);
      pix_store = req_data.mode ? 8'd0 : req_data.pixel;
      pix_now   = (row_ff < h_eff) ? pix_store : 8'd0;
      for (int q = 0; q < vng_pkg::WIN_N; q++) begin
         col_sum       = {1'b0, cc_now} + 14'(q);
         col_ok_now[q] = (col_sum >= 14'd2) && (col_sum < {1'b0, w_eff} + 14'd2);
      end
      for (int k = 0; k < 4; k++) begin
         row_sum       = {1'b0, row_ff} + 14'(k);
         row_ok_now[k] = (row_sum >= 14'd4) && (row_sum < {1'b0, h_eff} + 14'd4);
      end
   end

   for (genvar b = 0; b < 4; b++) begin : g_bank
      logic [7:0] mem [MAX_WIDTH];
      logic [7:0] q_ff;
      always_ff @(posedge clock) begin
         if (cmd.load) begin
            q_ff <= mem[AW'(col_now)];
            if (row_ff[1:0] == 2'(b)) begin
               mem[AW'(col_now)] <= pix_store;
            end
         end
      end
      assign bank_q[b] = q_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= vng_pkg::WIDTH_RESET;
         height_ff <= vng_pkg::HEIGHT_RESET;
         col_ff    <= '0;
         row_ff    <= '0;
      end else if (cmd.cfg) begin
         if (csr_index == vng_pkg::CSR_FRAME_WIDTH) begin
            width_ff <= csr_data;
            col_ff   <= '0;
            row_ff   <= '0;
         end else if (csr_index == vng_pkg::CSR_FRAME_HEIGHT) begin
            height_ff <= csr_data;
            col_ff    <= '0;
            row_ff    <= '0;
         end
      end else if (cmd.load) begin
         if (last_now) begin
            col_ff <= '0;
            row_ff <= '0;
         end else if (col_now + 13'd1 >= w_eff) begin
            col_ff <= '0;
            row_ff <= row_ff + 13'd1;
         end else begin
            col_ff <= col_now + 13'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         bank_ff   <= row_ff[1:0];
         pix_ff    <= pix_now;
         have_ff   <= have_now;
         kind_ff   <= ~(cr_now[0] ^ cc_now[0]);
         crodd_ff  <= cr_now[0];
         last_ff   <= last_now;
         col_ok_ff <= col_ok_now;
         row_ok_ff <= row_ok_now;
      end
   end

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         newcol[k] = row_ok_ff[k] ? bank_q[2'(bank_ff + 2'(k))] : 8'd0;
      end
      newcol[4] = pix_ff;
      for (int k = 0; k < vng_pkg::WIN_N; k++) begin
         for (int q = 0; q < vng_pkg::WIN_N; q++) begin
            a[k*5+q] = col_ok_ff[q] ? win_ff[k*5+q] : 8'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (cmd.cfg && (csr_index == vng_pkg::CSR_FRAME_WIDTH ||
                                csr_index == vng_pkg::CSR_FRAME_HEIGHT))) begin
         for (int i = 0; i < vng_pkg::WIN_CELLS; i++) begin
            win_ff[i] <= '0;
         end
      end else if (cmd.shift) begin
         for (int k = 0; k < vng_pkg::WIN_N; k++) begin
            for (int q = 0; q < vng_pkg::WIN_N - 1; q++) begin
               win_ff[k*5+q] <= win_ff[k*5+q+1];
            end
            win_ff[k*5+4] <= newcol[k];
         end
      end
   end

   always_comb begin
      g_sum = '0;
      for (int t = 0; t < 6; t++) begin
         gx = a[vng_pkg::GRAD_TAB[cmd.idx][t][0]];
         gy = a[vng_pkg::GRAD_TAB[cmd.idx][t][1]];
         ge = (gx > gy) ? gx - gy : gy - gx;
         g_sum = g_sum + ((t < 2) ? {2'b00, ge, 1'b0} : {3'b000, ge});
      end
      for (int t = 0; t < 3; t++) begin
         dir_sum[t] = '0;
         for (int q = 0; q < 4; q++) begin
            dir_sum[t] = dir_sum[t] + {2'b00, a[vng_pkg::SUM_TAB[kind_ff][cmd.idx][t][q]]};
         end
      end
      pass = {1'b0, g2_ff[cmd.idx], 1'b0} <= ({2'b00, mn_ff} << 1) + {2'b00, mx_ff};
   end

   always_ff @(posedge clock) begin
      if (cmd.grad) begin
         g2_ff[cmd.idx] <= g_sum;
         if (cmd.idx == 3'd0) begin
            mn_ff <= g_sum;
            mx_ff <= g_sum;
         end else begin
            if (g_sum < mn_ff) mn_ff <= g_sum;
            if (g_sum > mx_ff) mx_ff <= g_sum;
         end
      end
      if (cmd.sum) begin
         if (cmd.idx == 3'd0) begin
            cnt_ff <= {3'b000, pass};
            for (int t = 0; t < 3; t++) begin
               s_ff[t] <= pass ? {3'b000, dir_sum[t]} : '0;
            end
         end else if (pass) begin
            cnt_ff <= cnt_ff + 1'b1;
            for (int t = 0; t < 3; t++) begin
               s_ff[t] <= s_ff[t] + {3'b000, dir_sum[t]};
            end
         end
      end
   end

   always_comb begin
      sv0   = $signed({2'b00, s_ff[0]});
      sv1   = $signed({2'b00, s_ff[1]});
      sv2   = $signed({2'b00, s_ff[2]});
      other = sv1 - sv2;
      num   = '0;
      case (cmd.chan)
         vng_pkg::CHAN_BLUE: begin
            if (!kind_ff) num = (crodd_ff ? sv1 : sv2) - sv0;
            else          num = crodd_ff ? '0 : other;
         end
         vng_pkg::CHAN_GREEN: begin
            num = kind_ff ? sv0 - sv2 : '0;
         end
         vng_pkg::CHAN_RED: begin
            if (!kind_ff) num = (crodd_ff ? sv2 : sv1) - sv0;
            else          num = crodd_ff ? other : '0;
         end
         default: num = '0;
      endcase
      num_abs = num[vng_pkg::NUM_W-1] ? 15'(-num) : 15'(num);
      trial   = {rem_ff, quo_ff[vng_pkg::QUO_W-1]};
      ge_cnt  = trial >= {1'b0, cnt_ff};
      rem_in  = ge_cnt ? 4'(trial - {1'b0, cnt_ff}) : trial[3:0];
      quo_in  = {quo_ff[vng_pkg::QUO_W-2:0], ge_cnt};
      qs      = neg_ff ? -$signed({2'b00, quo_ff}) : $signed({2'b00, quo_ff});
      val     = $signed({5'b00000, a[12]}) + qs;
      if (val < 0) begin
         sat = 8'd0;
      end else if (val > 13'sd255) begin
         sat = 8'd255;
      end else begin
         sat = val[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         rem_ff <= '0;
         quo_ff <= num_abs[12:2];
         neg_ff <= num[vng_pkg::NUM_W-1];
      end else if (cmd.div_step) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
      if (cmd.div_fin) begin
         case (cmd.chan)
            vng_pkg::CHAN_BLUE:  blue_ff  <= sat;
            vng_pkg::CHAN_GREEN: green_ff <= sat;
            vng_pkg::CHAN_RED:   red_ff   <= sat;
            default:             blue_ff  <= blue_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.out_load) begin
         rsp_data_ff.blue       <= blue_ff;
         rsp_data_ff.green      <= green_ff;
         rsp_data_ff.red        <= red_ff;
         rsp_data_ff.frame_last <= last_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_data_ff;
   assign status.have     = have_ff;
   assign status.out_busy = rsp_valid_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !rsp_valid_ff)
      else $error("result register loaded while a word still waits");

   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      cmd.div_load |-> (cnt_ff != '0) && (cnt_ff <= 4'd8))
      else $error("direction count out of range at division");

   a_load_cfg_excl: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> !cmd.cfg)
      else $error("pixel load and register write in the same cycle");

   a_shift_after_load: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> cmd.shift)
      else $error("window shift did not follow a pixel load");

endmodule

`default_nettype wire

// ===== rtl/vng_bayer_demosaic.sv =====
// ---------------------------------------------------------------------------
// VNG Bayer demosaic (RGGB)
// Top level: controller and datapath joined by command and status words.
// ---------------------------------------------------------------------------
// An accepted pixel word that produces no colour result passes only through
// load and window shift. A word that produces a result goes through load and
// line store read, window shift, a gradient sweep over the eight directions,
// a threshold and sum sweep, a pass of the shared bit-serial divider for each
// of the three colours, then the hand-over of the result to the output
// register. Results lag the input by two rows and two pixels, and a frame
// needs 2*width+2 flush words after its last pixel. The line stores hold
// no reset value and need no clearing pass.
`default_nettype none

module vng_bayer_demosaic #(
   parameter int MAX_WIDTH = vng_pkg::MAX_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  vng_pkg::req_word_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output vng_pkg::rsp_word_type rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [1:0]            csr_index,
   input  logic [12:0]           csr_data
);

   vng_pkg::cmd_type    cmd;
   vng_pkg::status_type status;

   vng_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .status    (status),
      .cmd       (cmd)
   );

   vng_datapath #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
